// ===== rtl/core/lzc_pkg.sv =====
// Shared constants, types and the sign-class functions of the zero-crossing edge unit.
package lzc_pkg;

    // Stream and frame geometry.
    localparam int PIXEL_BITS  = 8;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);

    // Configuration register widths and port sizes.
    localparam int WIDTH_BITS     = 11;
    localparam int HEIGHT_BITS    = 13;
    localparam int BAND_BITS      = 8;
    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_INDEX_BITS = 2;
    localparam int EDGE_BITS      = 8;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_ZERO_BAND    = CFG_INDEX_BITS'(2);

    // Register values after reset.
    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(512);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(512);
    localparam logic [BAND_BITS-1:0]   BAND_RESET   = BAND_BITS'(3);

    // Sign classes of the scaled Laplacian.
    localparam int CLS_BITS = 2;
    typedef logic [CLS_BITS-1:0] cls_t;
    localparam cls_t CLS_ZERO = 2'd0;
    localparam cls_t CLS_POS  = 2'd1;
    localparam cls_t CLS_NEG  = 2'd2;

    // Output pixel values.
    localparam logic [EDGE_BITS-1:0] EDGE_MARK = EDGE_BITS'(0);
    localparam logic [EDGE_BITS-1:0] EDGE_NONE = EDGE_BITS'(255);

    // Signed width that holds 4*C - U - D - L - R.
    localparam int LAP_BITS = PIXEL_BITS + 3;

    // Laplacian, divided by four toward zero, then classed against the band.
    function automatic cls_t classify(
        input logic [PIXEL_BITS-1:0] ctr,
        input logic [PIXEL_BITS-1:0] up,
        input logic [PIXEL_BITS-1:0] dn,
        input logic [PIXEL_BITS-1:0] lf,
        input logic [PIXEL_BITS-1:0] rt,
        input logic [BAND_BITS-1:0]  band
    );
        logic signed [LAP_BITS-1:0] lap;
        logic signed [LAP_BITS-1:0] adj;
        logic signed [LAP_BITS-1:0] quo;
        logic signed [LAP_BITS-1:0] bnd;
        cls_t                       cls;
        lap = $signed({1'b0, ctr, 2'b00}) - $signed({3'b000, up}) - $signed({3'b000, dn})
            - $signed({3'b000, lf}) - $signed({3'b000, rt});
        // Adding three before the arithmetic shift makes negative values round toward zero.
        adj = lap + $signed({{(LAP_BITS-2){1'b0}}, {2{lap[LAP_BITS-1]}}});
        quo = adj >>> 2;
        bnd = $signed({{(LAP_BITS-BAND_BITS){1'b0}}, band});
        if (quo > -bnd && quo < bnd) begin
            cls = CLS_ZERO;
        end else if (quo <= -bnd) begin
            cls = CLS_NEG;
        end else begin
            cls = CLS_POS;
        end
        return cls;
    endfunction

    // A zero-class pixel between opposite classes, vertically or horizontally, is an edge.
    function automatic logic [EDGE_BITS-1:0] edge_of(
        input cls_t ctr,
        input cls_t up,
        input cls_t dn,
        input cls_t lf,
        input cls_t rt
    );
        logic [EDGE_BITS-1:0] val;
        val = EDGE_NONE;
        if (ctr == CLS_ZERO) begin
            if ((up == CLS_NEG && dn == CLS_POS) || (up == CLS_POS && dn == CLS_NEG) ||
                (lf == CLS_NEG && rt == CLS_POS) || (lf == CLS_POS && rt == CLS_NEG)) begin
                val = EDGE_MARK;
            end
        end
        return val;
    endfunction

endpackage

// ===== rtl/core/laplacian_zero_crossing_edge_unit.sv =====
// Top level of the Laplacian zero-crossing edge unit.
// A result is registered in the output register when its last pixel leaves the compute stage.
// Throughput: one pixel per cycle while m_ready holds; in the last row each pixel releases
// two results, and the output register holds the input there while it drains them.
// Reset (synchronous, active low) clears frame position, pipeline and output occupancy and
// loads the register defaults; the line buffers are not cleared and need no clearing pass.
module laplacian_zero_crossing_edge_unit
    import lzc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [PIXEL_BITS-1:0]     s_pixel,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [EDGE_BITS-1:0]      m_edge_value,
    output logic                      m_last_of_frame,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

    // Position flags of a pixel, captured at acceptance.
    typedef struct packed {
        logic [COL_BITS-1:0] col;
        logic                row_par;
        logic                row_first;
        logic                row_any;
        logic                row_third;
        logic                row_final;
        logic                col_first;
        logic                col_final;
        logic                col_from1;
        logic                col_from2;
    } lzc_ctl_t;

    // One result item.
    typedef struct packed {
        logic [EDGE_BITS-1:0] edge_value;
        logic                 last_flag;
    } lzc_res_t;

    logic [WIDTH_BITS-1:0]  cfg_width_reg;
    logic [HEIGHT_BITS-1:0] cfg_height_reg;
    logic [BAND_BITS-1:0]   cfg_band_reg;

    logic [COL_BITS-1:0] col_reg;
    logic [COL_BITS-1:0] col_next;
    logic [ROW_BITS-1:0] row_reg;
    logic [ROW_BITS-1:0] row_next;
    logic [COL_BITS-1:0] w_last;
    logic [ROW_BITS-1:0] h_last;

    logic     accept;
    logic     restart;
    lzc_ctl_t acc_ctl;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    lzc_ctl_t              s1_ctl_reg;
    logic [PIXEL_BITS-1:0] s1_pixel_reg;
    logic                  s1_go;

    logic [2*PIXEL_BITS-1:0] pix_rd_a;
    logic [2*PIXEL_BITS-1:0] pix_rd_b;
    logic [2*PIXEL_BITS-1:0] pix_wr_data;
    logic [2*CLS_BITS-1:0]   sgn_rd_a;
    logic [2*CLS_BITS-1:0]   sgn_rd_b;
    logic [2*CLS_BITS-1:0]   sgn_wr_data;

    logic [PIXEL_BITS-1:0] pix_cur_a;
    logic [PIXEL_BITS-1:0] pix_prv_a;
    logic [PIXEL_BITS-1:0] pix_prv_b;
    cls_t                  sgn_cur_a;
    cls_t                  sgn_prv_a;
    cls_t                  sgn_cur_b;

    logic [PIXEL_BITS-1:0] left_pix_reg;
    cls_t                  left_sgn_reg;
    cls_t                  fresh_d1_reg;
    cls_t                  fresh_d2_reg;
    logic [PIXEL_BITS-1:0] pix_d1_reg;
    logic [PIXEL_BITS-1:0] pix_d2_reg;

    logic [PIXEL_BITS-1:0] up_pix;
    logic [PIXEL_BITS-1:0] lf_pix;
    logic [PIXEL_BITS-1:0] rt_pix;
    cls_t                  fresh_cls;
    cls_t                  below_cls;
    logic                  res0_valid;
    logic                  res1_valid;
    lzc_res_t              res0;
    lzc_res_t              res1;

    logic [1:0] out_cnt_reg;
    logic [1:0] out_cnt_next;
    lzc_res_t   slot0_reg;
    lzc_res_t   slot0_next;
    lzc_res_t   slot1_reg;
    lzc_res_t   slot1_next;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= WIDTH_RESET;
            cfg_height_reg <= HEIGHT_RESET;
            cfg_band_reg   <= BAND_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_width_reg  <= cfg_wdata[WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT: cfg_height_reg <= cfg_wdata[HEIGHT_BITS-1:0];
                REG_ZERO_BAND:    cfg_band_reg   <= cfg_wdata[BAND_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Last column and last row after clamping the frame size to its legal range.
    always_comb begin
        if (cfg_width_reg < WIDTH_BITS'(3)) begin
            w_last = COL_BITS'(2);
        end else if (32'(cfg_width_reg) > 32'(MAX_WIDTH)) begin
            w_last = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            w_last = COL_BITS'(cfg_width_reg - WIDTH_BITS'(1));
        end
        if (cfg_height_reg < HEIGHT_BITS'(3)) begin
            h_last = ROW_BITS'(2);
        end else if (32'(cfg_height_reg) > 32'(MAX_HEIGHT)) begin
            h_last = ROW_BITS'(MAX_HEIGHT - 1);
        end else begin
            h_last = ROW_BITS'(cfg_height_reg - HEIGHT_BITS'(1));
        end
    end

    // Input handshake: a pixel enters whenever the compute stage is free or moves on.
    assign s_ready = !s1_valid_reg || s1_go;
    assign accept  = s_valid && s_ready;
    assign restart = cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

    // Raster position of the next pixel; a frame size write restarts the frame.
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (col_reg == w_last) begin
                col_next = '0;
                row_next = (row_reg == h_last) ? '0 : row_reg + ROW_BITS'(1);
            end else begin
                col_next = col_reg + COL_BITS'(1);
            end
        end
    end

    // Position flags of the pixel being accepted.
    always_comb begin
        acc_ctl.col       = col_reg;
        acc_ctl.row_par   = row_reg[0];
        acc_ctl.row_first = (row_reg == ROW_BITS'(1));
        acc_ctl.row_any   = (row_reg != '0);
        acc_ctl.row_third = (row_reg[ROW_BITS-1:2] != '0) || (row_reg[1:0] == 2'b11);
        acc_ctl.row_final = (row_reg == h_last);
        acc_ctl.col_first = (col_reg == '0);
        acc_ctl.col_final = (col_reg == w_last);
        acc_ctl.col_from1 = (col_reg != '0);
        acc_ctl.col_from2 = (col_reg[COL_BITS-1:1] != '0);
    end

    assign s1_valid_next = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            out_cnt_reg  <= 2'd0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
            out_cnt_reg  <= out_cnt_next;
        end
    end

    // Compute stage payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ctl_reg   <= acc_ctl;
            s1_pixel_reg <= s_pixel;
        end
    end

    // Both pixel rows share one word per column; port A reads column c, port B column c+1.
    lzc_ram #(
        .WIDTH (2 * PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_pix_ram (
        .aclk      (aclk),
        .wr_en     (s1_go),
        .wr_addr   (s1_ctl_reg.col),
        .wr_data   (pix_wr_data),
        .rd_a_en   (accept),
        .rd_a_addr (col_reg),
        .rd_a_data (pix_rd_a),
        .rd_b_en   (accept),
        .rd_b_addr (col_reg + COL_BITS'(1)),
        .rd_b_data (pix_rd_b)
    );

    // Sign classes of both rows, laid out the same way.
    lzc_ram #(
        .WIDTH (2 * CLS_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_sgn_ram (
        .aclk      (aclk),
        .wr_en     (s1_go && s1_ctl_reg.row_any),
        .wr_addr   (s1_ctl_reg.col),
        .wr_data   (sgn_wr_data),
        .rd_a_en   (accept),
        .rd_a_addr (col_reg),
        .rd_a_data (sgn_rd_a),
        .rd_b_en   (accept),
        .rd_b_addr (col_reg + COL_BITS'(1)),
        .rd_b_data (sgn_rd_b)
    );

    // Pick the current-row and previous-row halves by row parity.
    always_comb begin
        if (s1_ctl_reg.row_par) begin
            pix_cur_a = pix_rd_a[2*PIXEL_BITS-1:PIXEL_BITS];
            pix_prv_a = pix_rd_a[PIXEL_BITS-1:0];
            pix_prv_b = pix_rd_b[PIXEL_BITS-1:0];
            sgn_cur_a = sgn_rd_a[2*CLS_BITS-1:CLS_BITS];
            sgn_prv_a = sgn_rd_a[CLS_BITS-1:0];
            sgn_cur_b = sgn_rd_b[2*CLS_BITS-1:CLS_BITS];
        end else begin
            pix_cur_a = pix_rd_a[PIXEL_BITS-1:0];
            pix_prv_a = pix_rd_a[2*PIXEL_BITS-1:PIXEL_BITS];
            pix_prv_b = pix_rd_b[2*PIXEL_BITS-1:PIXEL_BITS];
            sgn_cur_a = sgn_rd_a[CLS_BITS-1:0];
            sgn_prv_a = sgn_rd_a[2*CLS_BITS-1:CLS_BITS];
            sgn_cur_b = sgn_rd_b[CLS_BITS-1:0];
        end
    end

    // Class of the pixel one row up, with mirrored top, left and right borders.
    always_comb begin
        up_pix    = s1_ctl_reg.row_first ? s1_pixel_reg : pix_cur_a;
        lf_pix    = s1_ctl_reg.col_first ? pix_prv_b : left_pix_reg;
        rt_pix    = s1_ctl_reg.col_final ? left_pix_reg : pix_prv_b;
        fresh_cls = classify(pix_prv_a, up_pix, s1_pixel_reg, lf_pix, rt_pix, cfg_band_reg);
    end

    // Class of the last row one column back, mirrored at the bottom.
    assign below_cls = classify(pix_d1_reg, left_pix_reg, left_pix_reg, pix_d2_reg,
                                s1_pixel_reg, cfg_band_reg);

    // Result two rows up, and in the last row the interleaved result of the row above.
    always_comb begin
        res0_valid      = s1_ctl_reg.row_third && s1_ctl_reg.col_from1 && !s1_ctl_reg.col_final;
        res0.edge_value = edge_of(sgn_cur_a, sgn_prv_a, fresh_cls, left_sgn_reg, sgn_cur_b);
        res0.last_flag  = 1'b0;
        res1_valid      = s1_ctl_reg.row_final && s1_ctl_reg.col_from2;
        res1.edge_value = edge_of(fresh_d1_reg, left_sgn_reg, below_cls, fresh_d2_reg,
                                  fresh_cls);
        res1.last_flag  = s1_ctl_reg.col_final;
    end

    // Write back the word of column c with the new pixel and the new class merged in.
    always_comb begin
        if (s1_ctl_reg.row_par) begin
            pix_wr_data = {s1_pixel_reg, pix_prv_a};
            sgn_wr_data = {sgn_cur_a, fresh_cls};
        end else begin
            pix_wr_data = {pix_prv_a, s1_pixel_reg};
            sgn_wr_data = {fresh_cls, sgn_cur_a};
        end
    end

    // Column window: left neighbors, this row's last two pixels and the classes above them.
    always_ff @(posedge aclk) begin
        if (s1_go) begin
            left_pix_reg <= pix_prv_a;
            left_sgn_reg <= sgn_cur_a;
            fresh_d1_reg <= fresh_cls;
            fresh_d2_reg <= fresh_d1_reg;
            pix_d1_reg   <= s1_pixel_reg;
            pix_d2_reg   <= pix_d1_reg;
        end
    end

    // The compute stage moves on once the output register will be empty.
    assign s1_go = s1_valid_reg &&
                   ((out_cnt_reg == 2'd0) || (out_cnt_reg == 2'd1 && m_ready));

    // Two-slot output register: drain one result per request, load up to two at once.
    always_comb begin
        out_cnt_next = out_cnt_reg;
        slot0_next   = slot0_reg;
        slot1_next   = slot1_reg;
        if (m_valid && m_ready) begin
            if (out_cnt_reg == 2'd2) begin
                out_cnt_next = 2'd1;
                slot0_next   = slot1_reg;
            end else begin
                out_cnt_next = 2'd0;
            end
        end
        if (s1_go) begin
            if (res0_valid) begin
                slot0_next   = res0;
                slot1_next   = res1;
                out_cnt_next = res1_valid ? 2'd2 : 2'd1;
            end else if (res1_valid) begin
                slot0_next   = res1;
                out_cnt_next = 2'd1;
            end else begin
                out_cnt_next = 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign m_valid         = (out_cnt_reg != 2'd0);
    assign m_edge_value    = slot0_reg.edge_value;
    assign m_last_of_frame = slot0_reg.last_flag;

endmodule

// ===== rtl/core/lzc_ram.sv =====
// Generic single-write, dual-read synchronous RAM with registered read data.
module lzc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_a_en,
    input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
    output logic [WIDTH-1:0]         rd_a_data,
    input  logic                     rd_b_en,
    input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
    output logic [WIDTH-1:0]         rd_b_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_data_reg;
    logic [WIDTH-1:0] rd_b_data_reg;

    // A read in the same cycle as a write to the same entry returns the old contents.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_a_en) begin
            rd_a_data_reg <= mem_reg[rd_a_addr];
        end
        if (rd_b_en) begin
            rd_b_data_reg <= mem_reg[rd_b_addr];
        end
    end

    assign rd_a_data = rd_a_data_reg;
    assign rd_b_data = rd_b_data_reg;

endmodule
